// ----- hw/rtl/two_sat_pkg.sv -----
// ----------------------------------------------------------------------------
// two_sat_pkg
// Types, codes and sizes shared by the 2-SAT solver.
// ----------------------------------------------------------------------------
package two_sat_pkg;

	localparam int NODE_W  = 7;   // literal node index
	localparam int ADJ_AW  = 8;   // adjacency word address: {from node, target half}
	localparam int ORD_W   = 8;   // visit order / low link
	localparam int CNT_W   = 8;   // stack depths, root and scan counters

	typedef enum logic [1:0] {
		ACT_ADD   = 2'd0,
		ACT_SOLVE = 2'd1,
		ACT_CLEAR = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		STS_STORED = 3'd0,
		STS_SAT    = 3'd1,
		STS_UNSAT  = 3'd2,
		STS_RANGE  = 3'd3,
		STS_CLEAR  = 3'd4
	} status_t;

	typedef struct packed {
		logic [1:0] action;
		logic [5:0] var_a;
		logic       neg_a;
		logic [5:0] var_b;
		logic       neg_b;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [63:0] assignment;
	} out_item_t;

	// One saved DFS frame of the walk
	typedef struct packed {
		logic [NODE_W-1:0] cur;
		logic [CNT_W-1:0]  nx;
		logic [ORD_W-1:0]  low;
		logic [ORD_W-1:0]  ord;
	} frame_t;

	typedef enum logic [4:0] {
		ST_CLR_ADJ,
		ST_IDLE,
		ST_ADD_RD1,
		ST_ADD_WR1,
		ST_ADD_RD2,
		ST_ADD_WR2,
		ST_SOL_CLR,
		ST_ROOT_RD,
		ST_ROOT_CHK,
		ST_SCAN,
		ST_EVAL,
		ST_CMP_RD,
		ST_CMP_WR,
		ST_POP_VO,
		ST_POP_LD,
		ST_CHK_A,
		ST_CHK_B,
		ST_CHK_C
	} state_t;

endpackage

// ----- hw/rtl/two_sat_solver.sv -----
// ----------------------------------------------------------------------------
// two_sat_solver
// 2-SAT solver: clause loading into an implication bit matrix, Tarjan SCC solve.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive item and raise start; the command transfers at a
//   rising edge with start high and busy low. action selects add clause,
//   solve or clear graph. Each command yields exactly one result on result,
//   marked by done for one cycle; the receiver cannot stall and need not.
//   Configuration: cfg_we with cfg_data writes num_vars (clamped to MAX_VARS); the user
//   must do so while idle, the block itself does not enforce it.
// Steps from transfer to done:
//   out-of-range clause or undefined action: answered straight from idle.
//   add clause: two read-modify-writes of the adjacency memory.
//   clear: one adjacency word zeroed per cycle.
//   solve: each candidate edge is read from the adjacency memory, then evaluated.
// One command is worked on at a time; busy stays high until its result is out,
// and the next command may transfer in the cycle that done is shown.
// Reset: adjacency memory swept to zero (all 2*NODES words), busy held high.
// ----------------------------------------------------------------------------
module two_sat_solver
	import two_sat_pkg::*;
#(
	parameter int MAX_VARS = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  in_item_t  item,
	input  logic      cfg_we,
	input  logic [6:0] cfg_data,
	output logic      done,
	output out_item_t result
);

	localparam int NODES     = 2 * MAX_VARS;
	localparam int ADJ_DEPTH = 2 * NODES;

	// ------------------------------------------------------------------
	// Memories: adjacency words, visit order, component label, node stack,
	// walk frames. All read synchronously, with registered read data.
	// ------------------------------------------------------------------
	logic [63:0]      adj_mem [0:ADJ_DEPTH-1];
	logic [ORD_W-1:0] vo_mem  [0:NODES-1];
	logic [ORD_W-1:0] cl_mem  [0:NODES-1];
	logic [NODE_W-1:0] ns_mem [0:NODES-1];
	frame_t           fr_mem  [0:NODES-1];

	logic [ADJ_AW-1:0] adj_raddr, adj_waddr;
	logic              adj_we;
	logic [63:0]       adj_wdata, adj_rd_q;

	logic [NODE_W-1:0] vo_raddr, vo_waddr, cl_raddr, cl_waddr;
	logic              vo_we, cl_we;
	logic [ORD_W-1:0]  vo_wdata, cl_wdata, vo_rd_q, cl_rd_q;

	logic [NODE_W-1:0] ns_raddr, ns_waddr, ns_wdata, ns_rd_q;
	logic              ns_we;

	logic [NODE_W-1:0] fr_raddr, fr_waddr;
	logic              fr_we;
	frame_t            fr_wdata, fr_rd_q;

	always_ff @(posedge clk) begin
		if (adj_we) begin
			adj_mem[adj_waddr] <= adj_wdata;
		end
		adj_rd_q <= adj_mem[adj_raddr];
	end

	always_ff @(posedge clk) begin
		if (vo_we) begin
			vo_mem[vo_waddr] <= vo_wdata;
		end
		vo_rd_q <= vo_mem[vo_raddr];
	end

	always_ff @(posedge clk) begin
		if (cl_we) begin
			cl_mem[cl_waddr] <= cl_wdata;
		end
		cl_rd_q <= cl_mem[cl_raddr];
	end

	always_ff @(posedge clk) begin
		if (ns_we) begin
			ns_mem[ns_waddr] <= ns_wdata;
		end
		ns_rd_q <= ns_mem[ns_raddr];
	end

	always_ff @(posedge clk) begin
		if (fr_we) begin
			fr_mem[fr_waddr] <= fr_wdata;
		end
		fr_rd_q <= fr_mem[fr_raddr];
	end

	// ------------------------------------------------------------------
	// Control and walk registers
	// ------------------------------------------------------------------
	state_t state_q, state_d;

	logic [6:0]        num_vars_q;
	logic [8:0]        sweep_q;      // clearing sweep counter
	logic              clr_resp_q;   // sweep was a clear command, not reset
	logic [NODE_W-1:0] la_q, lb_q;   // literal nodes of the clause in work
	logic [CNT_W-1:0]  root_q;
	logic [6:0]        chk_q;        // variable under final check
	logic [ORD_W-1:0]  chk_a_q;
	logic [ORD_W-1:0]  vclk_q;       // visit clock
	logic [CNT_W-1:0]  nsp_q, wsp_q; // node stack and walk depths
	logic [NODE_W-1:0] top_cur_q;
	logic [CNT_W-1:0]  top_nx_q;
	logic [ORD_W-1:0]  top_low_q, top_ord_q;
	logic [63:0]       value_q, value_set_q;

	logic      done_q;
	out_item_t result_q;

	logic [6:0]       n_act;
	logic [CNT_W-1:0] nodes;
	logic [6:0]       ex_a, ex_b;

	assign n_act = (num_vars_q > 7'(MAX_VARS)) ? 7'(MAX_VARS) : num_vars_q;
	assign nodes = {n_act, 1'b0};
	assign ex_a  = {1'b0, item.var_a};
	assign ex_b  = {1'b0, item.var_b};

	// Clause edges: la -> lb^1 and lb -> la^1
	logic [NODE_W-1:0] lb_n, la_n;
	assign lb_n = {lb_q[6:1], ~lb_q[0]};
	assign la_n = {la_q[6:1], ~la_q[0]};

	// Candidate evaluation during the scan
	logic edge_hit, cand_open, found;
	assign edge_hit  = adj_rd_q[top_nx_q[5:0]];
	assign cand_open = edge_hit && (cl_rd_q == '0);
	assign found     = cand_open && (vo_rd_q == '0);

	logic [ORD_W-1:0] vclk_inc;
	assign vclk_inc = vclk_q + 1'b1;

	logic [ORD_W-1:0] pop_low;
	assign pop_low = (top_low_q < fr_rd_q.low) ? top_low_q : fr_rd_q.low;

	logic              emit;
	status_t           emit_status;

	// ------------------------------------------------------------------
	// Next state, memory strobes
	// ------------------------------------------------------------------
	always_comb begin
		state_d     = state_q;
		emit        = 1'b0;
		emit_status = STS_STORED;
		adj_raddr   = '0;
		adj_we      = 1'b0;
		adj_waddr   = '0;
		adj_wdata   = '0;
		vo_raddr    = top_nx_q[NODE_W-1:0];
		vo_we       = 1'b0;
		vo_waddr    = '0;
		vo_wdata    = '0;
		cl_raddr    = top_nx_q[NODE_W-1:0];
		cl_we       = 1'b0;
		cl_waddr    = '0;
		cl_wdata    = '0;
		ns_raddr    = NODE_W'(nsp_q - 1'b1);
		ns_we       = 1'b0;
		ns_waddr    = nsp_q[NODE_W-1:0];
		ns_wdata    = '0;
		fr_raddr    = NODE_W'(wsp_q - 8'd2);
		fr_we       = 1'b0;
		fr_waddr    = NODE_W'(wsp_q - 1'b1);
		fr_wdata    = '{cur: top_cur_q, nx: top_nx_q + 1'b1, low: top_low_q,
		                ord: top_ord_q};

		case (state_q)
			ST_CLR_ADJ: begin
				adj_we    = 1'b1;
				adj_waddr = sweep_q[ADJ_AW-1:0];
				if (sweep_q == 9'(ADJ_DEPTH - 1)) begin
					state_d = ST_IDLE;
					if (clr_resp_q) begin
						emit        = 1'b1;
						emit_status = STS_CLEAR;
					end
				end
			end
			ST_IDLE: begin
				if (start) begin
					case (item.action)
						ACT_ADD: begin
							if (ex_a >= n_act || ex_b >= n_act) begin
								emit        = 1'b1;
								emit_status = STS_RANGE;
							end else begin
								state_d = ST_ADD_RD1;
							end
						end
						ACT_SOLVE: state_d = ST_SOL_CLR;
						ACT_CLEAR: state_d = ST_CLR_ADJ;
						default: begin
							emit        = 1'b1;
							emit_status = STS_RANGE;
						end
					endcase
				end
			end
			ST_ADD_RD1: begin
				adj_raddr = {la_q, lb_n[6]};
				state_d   = ST_ADD_WR1;
			end
			ST_ADD_WR1: begin
				adj_we    = 1'b1;
				adj_waddr = {la_q, lb_n[6]};
				adj_wdata = adj_rd_q | (64'd1 << lb_n[5:0]);
				state_d   = ST_ADD_RD2;
			end
			ST_ADD_RD2: begin
				adj_raddr = {lb_q, la_n[6]};
				state_d   = ST_ADD_WR2;
			end
			ST_ADD_WR2: begin
				adj_we      = 1'b1;
				adj_waddr   = {lb_q, la_n[6]};
				adj_wdata   = adj_rd_q | (64'd1 << la_n[5:0]);
				emit        = 1'b1;
				emit_status = STS_STORED;
				state_d     = ST_IDLE;
			end
			ST_SOL_CLR: begin
				vo_we    = 1'b1;
				vo_waddr = sweep_q[NODE_W-1:0];
				cl_we    = 1'b1;
				cl_waddr = sweep_q[NODE_W-1:0];
				if (sweep_q == 9'(NODES - 1)) begin
					state_d = ST_ROOT_RD;
				end
			end
			ST_ROOT_RD: begin
				cl_raddr = root_q[NODE_W-1:0];
				state_d  = (root_q >= nodes) ? ST_CHK_A : ST_ROOT_CHK;
			end
			ST_ROOT_CHK: begin
				if (cl_rd_q != '0) begin
					state_d = ST_ROOT_RD;
				end else begin
					// enter the root: fresh stacks
					vo_we    = 1'b1;
					vo_waddr = root_q[NODE_W-1:0];
					vo_wdata = vclk_inc;
					ns_we    = 1'b1;
					ns_waddr = '0;
					ns_wdata = root_q[NODE_W-1:0];
					state_d  = ST_SCAN;
				end
			end
			ST_SCAN: begin
				adj_raddr = {top_cur_q, top_nx_q[6]};
				if (top_nx_q >= nodes) begin
					state_d = (top_low_q == top_ord_q) ? ST_CMP_RD : ST_POP_VO;
				end else begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (found) begin
					vo_we    = 1'b1;
					vo_waddr = top_nx_q[NODE_W-1:0];
					vo_wdata = vclk_inc;
					ns_we    = 1'b1;
					ns_wdata = top_nx_q[NODE_W-1:0];
					fr_we    = 1'b1;
				end
				state_d = ST_SCAN;
			end
			ST_CMP_RD: begin
				state_d = (nsp_q == '0) ? ST_POP_VO : ST_CMP_WR;
			end
			ST_CMP_WR: begin
				cl_we    = 1'b1;
				cl_waddr = ns_rd_q;
				cl_wdata = top_low_q;
				state_d  = (ns_rd_q == top_cur_q) ? ST_POP_VO : ST_CMP_RD;
			end
			ST_POP_VO: begin
				vo_we    = 1'b1;
				vo_waddr = top_cur_q;
				vo_wdata = top_low_q;
				state_d  = (wsp_q > 8'd1) ? ST_POP_LD : ST_ROOT_RD;
			end
			ST_POP_LD: begin
				state_d = ST_SCAN;
			end
			ST_CHK_A: begin
				cl_raddr = {chk_q[5:0], 1'b0};
				if (chk_q >= n_act) begin
					emit        = 1'b1;
					emit_status = STS_SAT;
					state_d     = ST_IDLE;
				end else begin
					state_d = ST_CHK_B;
				end
			end
			ST_CHK_B: begin
				cl_raddr = {chk_q[5:0], 1'b1};
				state_d  = ST_CHK_C;
			end
			ST_CHK_C: begin
				if (cl_rd_q == chk_a_q) begin
					emit        = 1'b1;
					emit_status = STS_UNSAT;
					state_d     = ST_IDLE;
				end else begin
					state_d = ST_CHK_A;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR_ADJ;
		end else begin
			state_q <= state_d;
		end
	end

	// ------------------------------------------------------------------
	// Datapath registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_vars_q  <= 7'd64;
			sweep_q     <= '0;
			clr_resp_q  <= 1'b0;
			la_q        <= '0;
			lb_q        <= '0;
			root_q      <= '0;
			chk_q       <= '0;
			chk_a_q     <= '0;
			vclk_q      <= '0;
			nsp_q       <= '0;
			wsp_q       <= '0;
			top_cur_q   <= '0;
			top_nx_q    <= '0;
			top_low_q   <= '0;
			top_ord_q   <= '0;
			value_q     <= '0;
			value_set_q <= '0;
			done_q      <= 1'b0;
			result_q    <= '0;
		end else begin
			if (cfg_we) begin
				num_vars_q <= cfg_data;
			end

			done_q <= emit;
			if (emit) begin
				result_q.status     <= emit_status;
				result_q.assignment <= (emit_status == STS_SAT) ? value_q : 64'd0;
			end

			case (state_q)
				ST_CLR_ADJ: sweep_q <= sweep_q + 1'b1;
				ST_IDLE: begin
					sweep_q    <= '0;
					la_q       <= {item.var_a, item.neg_a};
					lb_q       <= {item.var_b, item.neg_b};
					clr_resp_q <= 1'b1;
					root_q     <= '0;
					chk_q      <= '0;
					vclk_q     <= '0;
					nsp_q      <= '0;
					wsp_q      <= '0;
					if (start && item.action == ACT_SOLVE) begin
						value_q     <= '0;
						value_set_q <= '0;
					end
				end
				ST_SOL_CLR: sweep_q <= sweep_q + 1'b1;
				ST_ROOT_CHK: begin
					if (cl_rd_q != '0) begin
						root_q <= root_q + 1'b1;
					end else begin
						vclk_q    <= vclk_inc;
						nsp_q     <= 8'd1;
						wsp_q     <= 8'd1;
						top_cur_q <= root_q[NODE_W-1:0];
						top_nx_q  <= '0;
						top_low_q <= vclk_inc;
						top_ord_q <= vclk_inc;
					end
				end
				ST_EVAL: begin
					if (found) begin
						// push the current frame, descend into the target
						vclk_q    <= vclk_inc;
						nsp_q     <= nsp_q + 1'b1;
						wsp_q     <= wsp_q + 1'b1;
						top_cur_q <= top_nx_q[NODE_W-1:0];
						top_nx_q  <= '0;
						top_low_q <= vclk_inc;
						top_ord_q <= vclk_inc;
					end else begin
						top_nx_q <= top_nx_q + 1'b1;
						if (cand_open && vo_rd_q < top_low_q) begin
							top_low_q <= vo_rd_q;
						end
					end
				end
				ST_CMP_RD: begin
					if (nsp_q != '0) begin
						nsp_q <= nsp_q - 1'b1;
					end
				end
				ST_CMP_WR: begin
					// first component to complete fixes the variable
					if (!value_set_q[ns_rd_q[6:1]]) begin
						value_set_q[ns_rd_q[6:1]] <= 1'b1;
						value_q[ns_rd_q[6:1]]     <= ns_rd_q[0];
					end
				end
				ST_POP_VO: begin
					if (wsp_q > 8'd1) begin
						wsp_q <= wsp_q - 1'b1;
					end else begin
						wsp_q  <= '0;
						root_q <= root_q + 1'b1;
					end
				end
				ST_POP_LD: begin
					top_cur_q <= fr_rd_q.cur;
					top_nx_q  <= fr_rd_q.nx;
					top_ord_q <= fr_rd_q.ord;
					top_low_q <= pop_low;
				end
				ST_CHK_B: chk_a_q <= cl_rd_q;
				ST_CHK_C: chk_q <= chk_q + 1'b1;
				default: ;
			endcase
		end
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_scan_has_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN || state_q == ST_EVAL) |-> (wsp_q != '0))
		else $error("scan without an open frame");

	a_idle_walk_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (wsp_q == '0))
		else $error("walk stack not empty when idle");

	a_stack_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(nsp_q <= 8'(NODES)) && (wsp_q <= 8'(NODES)))
		else $error("stack depth beyond node count");

	a_assign_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status != STS_SAT) |-> (result.assignment == 64'd0))
		else $error("assignment set on a non-satisfiable result");

endmodule
